FILE: src/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// types and constants for the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int QW        = 16;
    localparam int PROD_W    = 32;
    localparam int NUM_W     = 35;
    localparam int DEN_W     = 33;
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = 17;
    localparam int ENTRIES   = 9;

    localparam logic signed [QW-1:0] Q_MAX = 16'sd32767;

    typedef struct packed {
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
    } quat_t;

    typedef struct packed {
        logic signed [QW-1:0] r00;
        logic signed [QW-1:0] r01;
        logic signed [QW-1:0] r02;
        logic signed [QW-1:0] r10;
        logic signed [QW-1:0] r11;
        logic signed [QW-1:0] r12;
        logic signed [QW-1:0] r20;
        logic signed [QW-1:0] r21;
        logic signed [QW-1:0] r22;
        logic                 zero_input;
    } mat_t;

endpackage

FILE: src/qrm_stream.sv
// ----------------------------------------------------------------------------
// qrm_stream
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface qrm_stream #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/quaternion_to_rotation_matrix.sv
// throughput: one word per cycle while the output is not stalled, set by the 17 step
// pipelined divider (one quotient bit per stage, nine lanes side by side)
// stalls freeze every stage together, nothing is lost or repeated
// reset (rst_n, asynchronous) clears all valid bits, data registers keep
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// normalises a quaternion and gives its 3x3 rotation matrix in q1.15
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
    input  logic       clk,
    input  logic       rst_n,
    qrm_stream.sink    quat,
    qrm_stream.source  mat
);
    import qrm_pkg::*;

    logic en;

    // stage 1: input capture
    logic  s1_v_reg;
    quat_t s1_q_reg;

    // stage 2: products
    logic                     s2_v_reg;
    logic                     s2_zero_reg;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    // stage 3: numerators and squared norm
    logic                    s3_v_reg;
    logic                    s3_zero_reg;
    logic signed [NUM_W-1:0] num_reg [ENTRIES];
    logic [DEN_W-1:0]        n2_reg;

    // stage 4: magnitude and sign
    logic               s4_v_reg;
    logic               s4_zero_reg;
    logic [DEN_W-1:0]   mag_reg [ENTRIES];
    logic [ENTRIES-1:0] s4_neg_reg;
    logic [DEN_W-1:0]   s4_den_reg;

    // divider stages
    logic [DIV_STEPS-1:0] dv_reg;
    logic [DIV_STEPS-1:0] dzero_reg;
    logic [DEN_W-1:0]     dden_reg  [DIV_STEPS];
    logic [ENTRIES-1:0]   dneg_reg  [DIV_STEPS];
    logic [DEN_W-1:0]     drem_reg  [DIV_STEPS][ENTRIES];
    logic [QUO_W-1:0]     dquo_reg  [DIV_STEPS][ENTRIES];
    logic [DEN_W-1:0]     drem_next [DIV_STEPS][ENTRIES];
    logic [QUO_W-1:0]     dquo_next [DIV_STEPS][ENTRIES];

    // output
    logic out_v_reg;
    mat_t out_reg;
    mat_t out_next;

    logic signed [NUM_W-1:0] num_next [ENTRIES];
    logic signed [QW-1:0]    ent      [ENTRIES];

    assign en         = !out_v_reg || mat.ready;
    assign quat.ready = en;
    assign mat.valid  = out_v_reg;
    assign mat.data   = out_reg;

    always_comb
    begin
        num_next[0] = NUM_W'(ww_reg) + NUM_W'(xx_reg) - NUM_W'(yy_reg) - NUM_W'(zz_reg);
        num_next[1] = (NUM_W'(xy_reg) + NUM_W'(wz_reg)) <<< 1;
        num_next[2] = (NUM_W'(xz_reg) - NUM_W'(wy_reg)) <<< 1;
        num_next[3] = (NUM_W'(xy_reg) - NUM_W'(wz_reg)) <<< 1;
        num_next[4] = NUM_W'(ww_reg) - NUM_W'(xx_reg) + NUM_W'(yy_reg) - NUM_W'(zz_reg);
        num_next[5] = (NUM_W'(yz_reg) + NUM_W'(wx_reg)) <<< 1;
        num_next[6] = (NUM_W'(xz_reg) + NUM_W'(wy_reg)) <<< 1;
        num_next[7] = (NUM_W'(yz_reg) - NUM_W'(wx_reg)) <<< 1;
        num_next[8] = NUM_W'(ww_reg) - NUM_W'(xx_reg) - NUM_W'(yy_reg) + NUM_W'(zz_reg);
    end

    // one quotient bit per stage: first stage checks mag >= den, later ones shift first
    always_comb
    begin
        logic [DEN_W:0] sh;
        logic [DEN_W:0] dn;
        logic           ge;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (s == 0)
                begin
                    sh = {1'b0, mag_reg[e]};
                    dn = {1'b0, s4_den_reg};
                end
                else
                begin
                    sh = {drem_reg[s-1][e], 1'b0};
                    dn = {1'b0, dden_reg[s-1]};
                end
                ge = sh >= dn;
                drem_next[s][e] = ge ? DEN_W'(sh - dn) : DEN_W'(sh);
                if (s == 0)
                    dquo_next[s][e] = QUO_W'(ge);
                else
                    dquo_next[s][e] = {dquo_reg[s-1][e][QUO_W-2:0], ge};
            end
        end
    end

    // round half away from zero and saturate; a zero input gives the identity
    always_comb
    begin
        logic [QUO_W-1:0] qr;
        for (int e = 0; e < ENTRIES; e++)
        begin
            qr = QUO_W'(dquo_reg[DIV_STEPS-1][e] + QUO_W'(1)) >> 1;
            if (dneg_reg[DIV_STEPS-1][e])
                ent[e] = QW'(~qr[QW-1:0] + QW'(1));
            else if (qr[QW] || qr[QW-1])
                ent[e] = Q_MAX;
            else
                ent[e] = QW'(qr);
            if (dzero_reg[DIV_STEPS-1])
                ent[e] = (e == 0 || e == 4 || e == 8) ? Q_MAX : '0;
        end
        out_next.r00        = ent[0];
        out_next.r01        = ent[1];
        out_next.r02        = ent[2];
        out_next.r10        = ent[3];
        out_next.r11        = ent[4];
        out_next.r12        = ent[5];
        out_next.r20        = ent[6];
        out_next.r21        = ent[7];
        out_next.r22        = ent[8];
        out_next.zero_input = dzero_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            dv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= quat.valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            dv_reg    <= {dv_reg[DIV_STEPS-2:0], s4_v_reg};
            out_v_reg <= dv_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_q_reg <= quat.data;

            s2_zero_reg <= (s1_q_reg.qw == '0) && (s1_q_reg.qx == '0) &&
                           (s1_q_reg.qy == '0) && (s1_q_reg.qz == '0);
            ww_reg <= s1_q_reg.qw * s1_q_reg.qw;
            xx_reg <= s1_q_reg.qx * s1_q_reg.qx;
            yy_reg <= s1_q_reg.qy * s1_q_reg.qy;
            zz_reg <= s1_q_reg.qz * s1_q_reg.qz;
            xy_reg <= s1_q_reg.qx * s1_q_reg.qy;
            xz_reg <= s1_q_reg.qx * s1_q_reg.qz;
            yz_reg <= s1_q_reg.qy * s1_q_reg.qz;
            wx_reg <= s1_q_reg.qw * s1_q_reg.qx;
            wy_reg <= s1_q_reg.qw * s1_q_reg.qy;
            wz_reg <= s1_q_reg.qw * s1_q_reg.qz;

            s3_zero_reg <= s2_zero_reg;
            n2_reg <= DEN_W'(unsigned'(ww_reg)) + DEN_W'(unsigned'(xx_reg)) +
                      DEN_W'(unsigned'(yy_reg)) + DEN_W'(unsigned'(zz_reg));
            for (int e = 0; e < ENTRIES; e++)
                num_reg[e] <= num_next[e];

            s4_zero_reg <= s3_zero_reg;
            s4_den_reg  <= n2_reg;
            for (int e = 0; e < ENTRIES; e++)
            begin
                s4_neg_reg[e] <= num_reg[e][NUM_W-1];
                mag_reg[e]    <= num_reg[e][NUM_W-1] ? DEN_W'(-num_reg[e]) : DEN_W'(num_reg[e]);
            end

            for (int s = 0; s < DIV_STEPS; s++)
            begin
                if (s == 0)
                begin
                    dzero_reg[s] <= s4_zero_reg;
                    dden_reg[s]  <= s4_den_reg;
                    dneg_reg[s]  <= s4_neg_reg;
                end
                else
                begin
                    dzero_reg[s] <= dzero_reg[s-1];
                    dden_reg[s]  <= dden_reg[s-1];
                    dneg_reg[s]  <= dneg_reg[s-1];
                end
                for (int e = 0; e < ENTRIES; e++)
                begin
                    drem_reg[s][e] <= drem_next[s][e];
                    dquo_reg[s][e] <= dquo_next[s][e];
                end
            end

            out_reg <= out_next;
        end
    end

endmodule

FILE: src/qrm_checker.sv
// ----------------------------------------------------------------------------
// qrm_checker
// port level checks for the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
module qrm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          quat_ready,
    input logic          mat_valid,
    input logic          mat_ready,
    input qrm_pkg::mat_t mat_data
);
    import qrm_pkg::*;

    // a stalled output word stays
    assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> mat_valid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_ready |=> $stable(mat_data))
        else $error("output word changed while stalled");

    // input only held off by a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !quat_ready |-> mat_valid && !mat_ready)
        else $error("input stalled without output back pressure");

    // zero quaternion gives identity
    assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_data.zero_input |->
            mat_data.r00 == Q_MAX && mat_data.r11 == Q_MAX && mat_data.r22 == Q_MAX &&
            mat_data.r01 == '0 && mat_data.r02 == '0 && mat_data.r10 == '0 &&
            mat_data.r12 == '0 && mat_data.r20 == '0 && mat_data.r21 == '0)
        else $error("zero quaternion did not give identity");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .quat_ready (quat.ready),
    .mat_valid  (mat.valid),
    .mat_ready  (mat.ready),
    .mat_data   (mat.data)
);
